FILE: rtl/prq_pkg.sv
`timescale 1ns / 1ps
package prq_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CHANGE = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_PRESENT   = 2'd3
	} status_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] thread_id;
		logic [6:0] prio;
	} req_t;

	typedef struct packed {
		logic       head_valid;
		logic [7:0] head_thread;
		logic [5:0] entry_count;
		status_t    status;
	} rsp_t;

	typedef struct packed {
		logic [7:0] thread;
		logic [6:0] prio;
	} entry_t;

	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] raddr;
		logic              we;
		logic [ADDR_W-1:0] waddr;
		entry_t            wdata;
	} mem_req_t;

endpackage

FILE: rtl/priority_ready_queue.sv
`timescale 1ns / 1ps
// Priority ready list of up to QUEUE_DEPTH thread ids, kept sorted by ascending
// priority value; the head is the entry served next.
// Request channel (req_valid/req_ready, payload req): op add, remove, change
// priority or query head, with a thread id and a priority.
// Response channel (rsp_valid/rsp_ready, payload rsp): one transaction per
// request with head, entry count and status, taken after the operation.
// One request is worked on at a time; req_ready is high only while idle.
// Each operation first scans the list through the single memory read port and
// compare unit, then moves the entries between removal and insertion points,
// then reads the head and loads the response register. A query skips scan and
// move. The sequencer returns to idle after each response before the next
// request is taken.
// The response register frees the sequencer: a new request is taken while a
// response waits. If the receiver stalls with a response still held, the next
// one waits in its final state until the register frees up.
// Reset empties the list at once; the entry memory is not cleared.
module priority_ready_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  prq_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output prq_pkg::rsp_t  rsp
);
	import prq_pkg::*;

	mem_req_t mreq;
	entry_t   rdata;
	rsp_t     ctrl_rsp;
	rsp_t     rsp_q;
	logic     rsp_valid_q;
	logic     idle;
	logic     done;
	logic     out_free;

	assign req_ready = idle;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	prq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (req_valid && req_ready),
		.req      (req),
		.out_free (out_free),
		.rdata    (rdata),
		.idle     (idle),
		.done     (done),
		.rsp      (ctrl_rsp),
		.mreq     (mreq)
	);

	prq_mem u_mem (
		.clk     (clk),
		.mreq    (mreq),
		.rdata_q (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rsp_q <= ctrl_rsp;
		end
	end

endmodule

FILE: rtl/prq_mem.sv
`timescale 1ns / 1ps
module prq_mem (
	input  logic              clk,
	input  prq_pkg::mem_req_t mreq,
	output prq_pkg::entry_t   rdata_q
);
	import prq_pkg::*;

	entry_t entry_mem [QUEUE_DEPTH];

	always_ff @(posedge clk) begin
		if (mreq.we) begin
			entry_mem[mreq.waddr] <= mreq.wdata;
		end
		if (mreq.rd_en) begin
			rdata_q <= entry_mem[mreq.raddr];
		end
	end

endmodule

FILE: rtl/prq_ctrl.sv
`timescale 1ns / 1ps
module prq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  prq_pkg::req_t     req,
	input  logic              out_free,
	input  prq_pkg::entry_t   rdata,
	output logic              idle,
	output logic              done,
	output prq_pkg::rsp_t     rsp,
	output prq_pkg::mem_req_t mreq
);
	import prq_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_SHIFT = 5'b00100,
		S_HEAD  = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t            state_q;
	op_t               op_q;
	logic [7:0]        id_q;
	logic [6:0]        prio_q;
	logic [CNT_W-1:0]  len_q;
	logic [CNT_W-1:0]  idx_q;
	logic              rd_vld_q;
	logic [ADDR_W-1:0] rd_idx_q;
	logic              found_q;
	logic [ADDR_W-1:0] fpos_q;
	logic [CNT_W-1:0]  less_q;
	logic              ins_q;
	logic              up_q;
	status_t           status_q;
	logic [ADDR_W-1:0] rptr_q;
	logic [ADDR_W-1:0] kpos_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              wr_vld_s1;
	logic [ADDR_W-1:0] waddr_s1;

	logic              scan_done;
	logic              full;
	logic [CNT_W-1:0]  f_pos;
	logic              ins_c;
	logic              rem_c;
	logic              up_c;
	logic [CNT_W-1:0]  moves_c;
	logic [CNT_W-1:0]  new_len_c;
	status_t           status_c;
	logic              hit;
	logic              lower;

	assign scan_done = (idx_q >= len_q) && !rd_vld_q;
	assign full      = (len_q == CNT_W'(QUEUE_DEPTH));
	// removal point; an absent id removes nothing and behaves as a removal at the tail
	assign f_pos     = found_q ? CNT_W'(fpos_q) : len_q;
	assign hit       = (rdata.thread == id_q);
	assign lower     = (rdata.prio < prio_q);

	always_comb begin
		ins_c    = 1'b0;
		rem_c    = 1'b0;
		status_c = ST_OK;
		case (op_q)
			OP_ADD: begin
				if (found_q) begin
					status_c = ST_PRESENT;
				end else if (full) begin
					status_c = ST_FULL;
				end else begin
					ins_c = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (found_q) begin
					rem_c = 1'b1;
				end else begin
					status_c = ST_NOT_FOUND;
				end
			end
			OP_CHANGE: begin
				if (found_q) begin
					rem_c = 1'b1;
					ins_c = 1'b1;
				end else if (full) begin
					status_c = ST_FULL;
				end else begin
					ins_c = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		up_c = ins_c && (less_q <= f_pos);
		if (ins_c) begin
			moves_c = up_c ? (f_pos - less_q) : (less_q - f_pos);
		end else if (rem_c) begin
			moves_c = len_q - CNT_W'(1) - f_pos;
		end else begin
			moves_c = '0;
		end
		new_len_c = len_q + CNT_W'(ins_c) - CNT_W'(rem_c);
	end

	always_comb begin
		mreq       = '0;
		mreq.wdata = rdata;
		case (state_q)
			S_SCAN: begin
				mreq.rd_en = (idx_q < len_q);
				mreq.raddr = idx_q[ADDR_W-1:0];
			end
			S_SHIFT: begin
				mreq.rd_en = (cnt_q != '0);
				mreq.raddr = rptr_q;
			end
			S_HEAD: begin
				mreq.rd_en = 1'b1;
			end
			default: begin
			end
		endcase
		if (wr_vld_s1) begin
			mreq.we    = 1'b1;
			mreq.waddr = waddr_s1;
		end else if (state_q == S_SHIFT && cnt_q == '0 && ins_q) begin
			// drop the new entry into the gap once every move has landed
			mreq.we          = 1'b1;
			mreq.waddr       = kpos_q;
			mreq.wdata       = '{thread: id_q, prio: prio_q};
		end
	end

	assign idle = (state_q == S_IDLE);
	assign done = (state_q == S_DONE) && out_free;

	always_comb begin
		rsp.head_valid  = (len_q != '0);
		rsp.head_thread = (len_q != '0) ? rdata.thread : 8'd0;
		rsp.entry_count = 6'(len_q);
		rsp.status      = status_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			len_q     <= '0;
			idx_q     <= '0;
			rd_vld_q  <= 1'b0;
			found_q   <= 1'b0;
			less_q    <= '0;
			cnt_q     <= '0;
			wr_vld_s1 <= 1'b0;
			ins_q     <= 1'b0;
			up_q      <= 1'b0;
			status_q  <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						status_q <= ST_OK;
						idx_q    <= '0;
						found_q  <= 1'b0;
						less_q   <= '0;
						rd_vld_q <= 1'b0;
						state_q  <= (req.op == OP_QUERY) ? S_HEAD : S_SCAN;
					end
				end
				S_SCAN: begin
					if (idx_q < len_q) begin
						idx_q    <= idx_q + CNT_W'(1);
						rd_vld_q <= 1'b1;
					end else begin
						rd_vld_q <= 1'b0;
					end
					if (rd_vld_q) begin
						if (hit && !found_q) begin
							found_q <= 1'b1;
						end
						// count entries other than the target that sort ahead
						if (!hit && lower) begin
							less_q <= less_q + CNT_W'(1);
						end
					end
					if (scan_done) begin
						status_q <= status_c;
						ins_q    <= ins_c;
						up_q     <= up_c;
						cnt_q    <= moves_c;
						len_q    <= new_len_c;
						state_q  <= (ins_c || rem_c) ? S_SHIFT : S_HEAD;
					end
				end
				S_SHIFT: begin
					if (cnt_q != '0) begin
						cnt_q     <= cnt_q - CNT_W'(1);
						wr_vld_s1 <= 1'b1;
					end else begin
						wr_vld_s1 <= 1'b0;
						if (!wr_vld_s1) begin
							state_q <= S_HEAD;
						end
					end
				end
				S_HEAD: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q   <= req.op;
			id_q   <= req.thread_id;
			prio_q <= req.prio;
		end
		if (state_q == S_SCAN) begin
			rd_idx_q <= idx_q[ADDR_W-1:0];
			if (rd_vld_q && hit && !found_q) begin
				fpos_q <= rd_idx_q;
			end
			if (scan_done) begin
				kpos_q <= less_q[ADDR_W-1:0];
				rptr_q <= up_c ? ADDR_W'(f_pos - CNT_W'(1)) : ADDR_W'(f_pos + CNT_W'(1));
			end
		end
		if (state_q == S_SHIFT && cnt_q != '0) begin
			rptr_q   <= up_q ? (rptr_q - ADDR_W'(1)) : (rptr_q + ADDR_W'(1));
			waddr_s1 <= up_q ? (rptr_q + ADDR_W'(1)) : (rptr_q - ADDR_W'(1));
		end
	end

endmodule

FILE: rtl/prq_check.sv
`timescale 1ns / 1ps
module prq_check (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input prq_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input prq_pkg::rsp_t rsp
);
	import prq_pkg::*;

	// hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// the sequencer is busy right after taking a request
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	a_head_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.head_valid == (rsp.entry_count != 6'd0)))
		else $error("head flag does not match count");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.head_valid |-> rsp.head_thread == 8'd0)
		else $error("empty list reports a head");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> 32'(rsp.entry_count) <= QUEUE_DEPTH)
		else $error("entry count above depth");

endmodule

bind priority_ready_queue prq_check u_prq_check (.*);

FILE: tb/sv/prq_list_checker.sv
`timescale 1ns / 1ps
module prq_list_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_ready,
	input  prq_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_ready,
	input  prq_pkg::rsp_t rsp,
	output int            errors,
	output int            owed
);
	import prq_pkg::*;

	logic [7:0] list_thread [QUEUE_DEPTH];
	logic [6:0] list_prio [QUEUE_DEPTH];
	int         list_len;
	rsp_t       heads_due_q [$];

	initial begin
		errors = 0;
		owed = 0;
		list_len = 0;
	end

	function automatic int find_thread(logic [7:0] id);
		for (int i = 0; i < list_len; i++) begin
			if (list_thread[i] == id)
				return i;
		end
		return list_len;
	endfunction

	function automatic void drop_at(int pos);
		for (int i = pos; i + 1 < list_len; i++) begin
			list_thread[i] = list_thread[i + 1];
			list_prio[i] = list_prio[i + 1];
		end
		list_len--;
	endfunction

	// Insert ahead of the first entry whose priority is >= p.
	function automatic bit insert_sorted(logic [7:0] id, logic [6:0] p);
		int pos;
		pos = 0;
		if (list_len >= QUEUE_DEPTH)
			return 1'b0;
		while (pos < list_len && list_prio[pos] < p)
			pos++;
		for (int i = list_len; i > pos; i--) begin
			list_thread[i] = list_thread[i - 1];
			list_prio[i] = list_prio[i - 1];
		end
		list_thread[pos] = id;
		list_prio[pos] = p;
		list_len++;
		return 1'b1;
	endfunction

	function automatic rsp_t apply_request(req_t r);
		rsp_t res;
		int   pos;
		res.status = ST_OK;
		case (r.op)
			OP_ADD: begin
				if (find_thread(r.thread_id) < list_len)
					res.status = ST_PRESENT;
				else if (!insert_sorted(r.thread_id, r.prio))
					res.status = ST_FULL;
			end
			OP_REMOVE: begin
				pos = find_thread(r.thread_id);
				if (pos < list_len)
					drop_at(pos);
				else
					res.status = ST_NOT_FOUND;
			end
			OP_CHANGE: begin
				pos = find_thread(r.thread_id);
				if (pos < list_len)
					drop_at(pos);
				if (!insert_sorted(r.thread_id, r.prio))
					res.status = ST_FULL;
			end
			default: begin
			end
		endcase
		res.head_valid = (list_len > 0);
		res.head_thread = (list_len > 0) ? list_thread[0] : 8'd0;
		res.entry_count = 6'(list_len);
		return res;
	endfunction

	function automatic void note_failure(string msg);
		errors++;
		if (errors <= 10)
			$display("%0t prq_list_checker: %s", $time, msg);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t due;
		if (!arst_n) begin
			list_len = 0;
			heads_due_q.delete();
		end else begin
			// Compare first: a response never belongs to the request taken on the same edge.
			if (rsp_valid && rsp_ready) begin
				if (heads_due_q.size() == 0) begin
					note_failure($sformatf("response with nothing owed: %h", rsp));
				end else begin
					due = heads_due_q.pop_front();
					if (rsp.head_valid !== due.head_valid || rsp.head_thread !== due.head_thread ||
						rsp.entry_count !== due.entry_count || rsp.status !== due.status)
						note_failure($sformatf({"expected valid=%0b head=%0d count=%0d status=%0d,",
							" got valid=%0b head=%0d count=%0d status=%0d"},
							due.head_valid, due.head_thread, due.entry_count, due.status,
							rsp.head_valid, rsp.head_thread, rsp.entry_count, rsp.status));
				end
			end
			if (req_valid && req_ready)
				heads_due_q.push_back(apply_request(req));
		end
		owed = heads_due_q.size();
	end

endmodule

FILE: tb/sv/priority_ready_queue_tb.sv
`timescale 1ns / 1ps
module priority_ready_queue_tb;
	import prq_pkg::*;

	localparam int ITEM_TOTAL    = 1900;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 2 * QUEUE_DEPTH + 16;
	localparam int POOL_SIZE     = 40;

	typedef enum int {
		MIX_FILL,
		MIX_CHURN,
		MIX_DRAIN
	} mix_t;

	typedef enum int {
		STALL_NONE,
		STALL_HALF,
		STALL_HEAVY,
		STALL_DUTY
	} stall_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   req_valid = 1'b0;
	logic   req_ready;
	req_t   req = '0;
	logic   rsp_valid;
	logic   rsp_ready = 1'b0;
	rsp_t   rsp;
	int     errors;
	int     owed;
	int     cycle_count = 0;
	int     burst_left = 0;
	stall_t stall_mode = STALL_NONE;
	int     stall_left = 0;
	logic [7:0] id_pool [POOL_SIZE];

	always #5 clk = ~clk;

	priority_ready_queue uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	prq_list_checker list_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.errors    (errors),
		.owed      (owed)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("priority_ready_queue_tb: done, errors");
			$finish;
		end
	end

	// Receiver: switch at random between stall patterns and hold each for a random stretch.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(20, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			STALL_NONE:  rsp_ready <= 1'b1;
			STALL_HALF:  rsp_ready <= ($urandom_range(0, 1) == 1);
			STALL_HEAVY: rsp_ready <= ($urandom_range(0, 3) == 0);
			default:     rsp_ready <= ((cycle_count % 8) < 5);
		endcase
	end

	// Hold the transaction until taken, then either continue the burst or idle a while.
	task automatic send_request(op_t op, logic [7:0] id, logic [6:0] p);
		int gap;
		req <= '{op: op, thread_id: id, prio: p};
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			burst_left = $urandom_range(0, 15);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic random_request(mix_t mix);
		int         roll;
		int         add_pct;
		int         remove_pct;
		int         change_pct;
		op_t        op;
		logic [7:0] id;
		logic [6:0] p;
		case (mix)
			MIX_FILL: begin
				add_pct = 60; remove_pct = 10; change_pct = 20;
			end
			MIX_CHURN: begin
				add_pct = 30; remove_pct = 30; change_pct = 25;
			end
			default: begin
				add_pct = 10; remove_pct = 65; change_pct = 10;
			end
		endcase
		roll = $urandom_range(0, 99);
		if (roll < add_pct)
			op = OP_ADD;
		else if (roll < add_pct + remove_pct)
			op = OP_REMOVE;
		else if (roll < add_pct + remove_pct + change_pct)
			op = OP_CHANGE;
		else
			op = OP_QUERY;
		// Mostly ids from a small pool so removes and duplicates hit; some strays.
		id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : id_pool[$urandom_range(0, POOL_SIZE - 1)];
		// Narrow priorities half the time to pile up equal peers.
		p = ($urandom_range(0, 1) == 1) ? 7'($urandom_range(0, 3)) : 7'($urandom_range(0, 127));
		send_request(op, id, p);
	endtask

	initial begin
		int   mix_left;
		mix_t mix;
		for (int i = 0; i < POOL_SIZE; i++)
			id_pool[i] = 8'($urandom);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(OP_QUERY, 8'd0, 7'd0);
		send_request(OP_REMOVE, 8'd0, 7'd0);
		send_request(OP_CHANGE, 8'd255, 7'd127);
		send_request(OP_ADD, 8'd255, 7'd0);
		send_request(OP_ADD, 8'd0, 7'd127);
		send_request(OP_ADD, 8'h55, 7'd0);
		send_request(OP_ADD, 8'hAA, 7'd0);
		send_request(OP_CHANGE, 8'h55, 7'd0);
		send_request(OP_CHANGE, 8'd0, 7'd64);
		send_request(OP_ADD, 8'h5A, 7'h2A);
		send_request(OP_ADD, 8'hA5, 7'h55);
		send_request(OP_QUERY, 8'hFF, 7'h7F);
		send_request(OP_REMOVE, 8'hAA, 7'd0);
		send_request(OP_REMOVE, 8'hAA, 7'd0);
		send_request(OP_REMOVE, 8'h55, 7'd0);
		send_request(OP_REMOVE, 8'd255, 7'd0);
		send_request(OP_REMOVE, 8'd0, 7'd0);
		send_request(OP_REMOVE, 8'h5A, 7'd0);
		send_request(OP_REMOVE, 8'hA5, 7'd0);
		send_request(OP_QUERY, 8'd0, 7'd0);

		mix_left = 0;
		mix = MIX_FILL;
		for (int n = 0; n < ITEM_TOTAL; n++) begin
			if (mix_left == 0) begin
				mix = mix_t'($urandom_range(0, 2));
				mix_left = $urandom_range(60, 200);
			end
			mix_left--;
			random_request(mix);
		end
		req_valid <= 1'b0;

		@(posedge clk);
		while (owed != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && owed == 0)
			$display("priority_ready_queue_tb: done, clean");
		else
			$display("priority_ready_queue_tb: done, errors");
		$finish;
	end

endmodule
